// ----- design/assert_macros.svh -----
// Assertion macros shared by the sprite select RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising clock edge outside reset.
`define OAMLS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Same-cycle implication.
`define OAMLS_ASSERT_IMPL(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication.
`define OAMLS_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- design/oamls_pkg.sv -----
// Types, codes and constants of the line sprite select block.
`default_nettype none

package oamls_pkg;

   // Default sizes
   localparam int TABLE_ENTRIES_DEF = 40;
   localparam int MAX_PER_LINE_DEF  = 10;

   // Scan line bias: line + 16 is compared against the sprite y byte
   localparam int LINE_OFFSET = 16;

   // Request commands
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_SCAN  = 2'd2;

   // Response kinds
   localparam logic [1:0] KIND_READ   = 2'd0;
   localparam logic [1:0] KIND_WRITE  = 2'd1;
   localparam logic [1:0] KIND_SPRITE = 2'd2;
   localparam logic [1:0] KIND_EMPTY  = 2'd3;

   localparam logic [4:0] HEIGHT_RESET = 5'd8;
   localparam logic [7:0] READ_MISS   = 8'hFF;

   typedef logic [7:0] byte_type;
   typedef logic [5:0] slot_type;
   typedef logic [4:0] height_type;

   typedef struct packed {
      logic [1:0] command;
      byte_type   byte_address;
      byte_type   write_data;
      byte_type   line;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      byte_type   read_data;
      byte_type   sprite_y;
      byte_type   sprite_x;
      byte_type   sprite_tile;
      byte_type   sprite_attr;
      slot_type   sprite_slot;
      logic       last;
   } rsp_type;

   // One table entry, y in the low byte
   typedef struct packed {
      byte_type attr;
      byte_type tile;
      byte_type x;
      byte_type y;
   } entry_type;

   // One selected sprite of the line list
   typedef struct packed {
      slot_type  slot;
      entry_type entry;
   } pick_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_SCAN,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

// ----- design/oamls_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module oamls_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 40,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/oam_line_sprite_select_unit.sv -----
// Sprite attribute table with per-line sprite selection, sorted by x.
//
// Channels: req_ carries one command (write byte, read byte, scan line); rsp_
// carries results. A transaction moves when valid is high and stall is low.
// csr_write_enable loads the 5-bit sprite height (8 after reset).
// Write and read: one result each (table read, then merge and write back or
// byte select into the output register).
// Scan: the table RAM is read one entry per cycle, and the walk ends early once
// MAX_PER_LINE sprites are held; hits are inserted in x order into a register
// row as they arrive. The row then drains 1 to MAX_PER_LINE results, one per
// cycle while the output register is not stalled.
// One command is worked at a time; the next is taken as soon as the last
// result sits in the output register, even while that result is stalled.
// A stalled output register holds its result; write, read and drain steps wait.
// Reset (synchronous) clears the entry valid bits, so the whole table reads
// as zero at once with no clearing pass; line count clears, height goes to 8.
// Out-of-range byte addresses: writes are dropped, reads return 0xFF.
`default_nettype none
`include "assert_macros.svh"

module oam_line_sprite_select_unit #(
   parameter int TABLE_ENTRIES = oamls_pkg::TABLE_ENTRIES_DEF,
   parameter int MAX_PER_LINE  = oamls_pkg::MAX_PER_LINE_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire oamls_pkg::height_type csr_write_data,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire oamls_pkg::req_type    req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output oamls_pkg::rsp_type         rsp_data
);

   localparam int AddrW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int IdxW  = $clog2(TABLE_ENTRIES + 1);
   localparam int ListW = (MAX_PER_LINE > 1) ? $clog2(MAX_PER_LINE) : 1;
   localparam int CntW  = $clog2(MAX_PER_LINE + 1);
   localparam int EntW  = $bits(oamls_pkg::entry_type);

   localparam logic [CntW-1:0] MaxCnt   = CntW'(MAX_PER_LINE);
   localparam logic [IdxW-1:0] LastIdx  = IdxW'(TABLE_ENTRIES);
   localparam logic [6:0]      TableTop = 7'(TABLE_ENTRIES);
   localparam logic [8:0]      LineBias = 9'(oamls_pkg::LINE_OFFSET);

   // Registers and next values
   oamls_pkg::state_type       state_ff, state_in;
   oamls_pkg::req_type         req_ff, req_in;
   oamls_pkg::height_type      height_ff, height_in;
   logic [TABLE_ENTRIES-1:0]   valid_ff, valid_in;
   logic                       rd_ok_ff, rd_ok_in;
   logic [IdxW-1:0]            scan_idx_ff, scan_idx_in;
   logic                       pend_ff, pend_in;
   logic [AddrW-1:0]           pend_idx_ff, pend_idx_in;
   logic [CntW-1:0]            count_ff, count_in;
   logic [CntW-1:0]            emit_ff, emit_in;
   oamls_pkg::pick_type        list_ff [MAX_PER_LINE];
   oamls_pkg::pick_type        list_in [MAX_PER_LINE];
   logic                       rsp_valid_ff, rsp_valid_in;
   oamls_pkg::rsp_type         rsp_ff, rsp_in;

   // RAM port
   logic [AddrW-1:0]           ram_rd_addr;
   logic [EntW-1:0]            ram_rd_bits;
   logic                       ram_wr_en;
   logic [EntW-1:0]            ram_wr_data;

   // Datapath helpers
   logic                       req_accept;
   logic                       out_free;
   logic                       held_in_range;
   logic [AddrW-1:0]           held_addr;
   logic [1:0]                 held_lane;
   oamls_pkg::entry_type       base_entry;
   logic [EntW-1:0]            merged_bits;
   oamls_pkg::byte_type        read_byte;
   logic [8:0]                 target;
   logic                       hit_match;
   logic                       hit;
   logic                       issue;
   logic                       scan_done;
   logic                       rsp_load;
   logic                       emit_last;
   oamls_pkg::pick_type        new_pick;
   oamls_pkg::pick_type        emit_pick;
   oamls_pkg::pick_type        list_ins [MAX_PER_LINE];
   oamls_pkg::pick_type        below    [MAX_PER_LINE];
   logic [MAX_PER_LINE-1:0]    gt;
   logic [MAX_PER_LINE-1:0]    prev_gt;

   oamls_ram #(
      .WIDTH (EntW),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (held_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_bits)
   );

   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != oamls_pkg::ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // Decode the held byte address
   assign held_addr     = req_ff.byte_address[AddrW+1:2];
   assign held_lane     = req_ff.byte_address[1:0];
   assign held_in_range = ({1'b0, req_ff.byte_address[7:2]} < TableTop);

   // Entries never written read as zero
   assign base_entry = rd_ok_ff ? oamls_pkg::entry_type'(ram_rd_bits)
                                : oamls_pkg::entry_type'('0);

   // Merge a written byte into the entry
   always_comb begin
      merged_bits                          = base_entry;
      merged_bits[{held_lane, 3'b000} +: 8] = req_ff.write_data;
   end
   assign ram_wr_data = merged_bits;

   // Select the read byte
   always_comb begin
      unique case (held_lane)
         2'd0:    read_byte = base_entry.y;
         2'd1:    read_byte = base_entry.x;
         2'd2:    read_byte = base_entry.tile;
         default: read_byte = base_entry.attr;
      endcase
   end

   // Line hit test on the entry in flight
   assign target    = {1'b0, req_ff.line} + LineBias;
   assign hit_match = (base_entry.x != '0)
                      && (target >= {1'b0, base_entry.y})
                      && (target < ({1'b0, base_entry.y} + 9'(height_ff)));
   assign hit       = pend_ff && (count_ff < MaxCnt) && hit_match;
   assign issue     = (scan_idx_ff < LastIdx);
   assign scan_done = (count_ff == MaxCnt) || (!pend_ff && !issue);
   assign new_pick  = '{slot: oamls_pkg::slot_type'(pend_idx_ff), entry: base_entry};

   // Stable insertion: each cell compares its x against the new sprite
   always_comb begin
      for (int k = 0; k < MAX_PER_LINE; k++) begin
         gt[k] = (CntW'(k) < count_ff) && (list_ff[k].entry.x > base_entry.x);
      end
      prev_gt[0] = 1'b0;
      below[0]   = new_pick;
      for (int k = 1; k < MAX_PER_LINE; k++) begin
         prev_gt[k] = gt[k-1];
         below[k]   = list_ff[k-1];
      end
      for (int k = 0; k < MAX_PER_LINE; k++) begin
         if (prev_gt[k]) begin
            list_ins[k] = below[k];
         end else if ((CntW'(k) == count_ff) || gt[k]) begin
            list_ins[k] = new_pick;
         end else begin
            list_ins[k] = list_ff[k];
         end
      end
   end

   // Head of the drain
   assign emit_pick = list_ff[emit_ff[ListW-1:0]];
   assign emit_last = ((emit_ff + CntW'(1)) == count_ff);

   // Next state and datapath control
   always_comb begin
      state_in    = state_ff;
      req_in      = req_ff;
      height_in   = csr_write_enable ? csr_write_data : height_ff;
      valid_in    = valid_ff;
      scan_idx_in = scan_idx_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      count_in    = count_ff;
      emit_in     = emit_ff;
      list_in     = list_ff;
      rsp_load    = 1'b0;
      rsp_in      = rsp_ff;
      ram_rd_addr = held_addr;
      ram_wr_en   = 1'b0;

      unique case (state_ff)
         oamls_pkg::ST_IDLE: begin
            ram_rd_addr = req_data.byte_address[AddrW+1:2];
            if (req_accept) begin
               req_in = req_data;
               if (req_data.command == oamls_pkg::CMD_WRITE) begin
                  state_in = oamls_pkg::ST_WRITE;
               end else if (req_data.command == oamls_pkg::CMD_READ) begin
                  state_in = oamls_pkg::ST_READ;
               end else if (req_data.command == oamls_pkg::CMD_SCAN) begin
                  state_in    = oamls_pkg::ST_SCAN;
                  scan_idx_in = '0;
                  count_in    = '0;
               end
            end
         end

         oamls_pkg::ST_WRITE: begin
            if (out_free) begin
               ram_wr_en = held_in_range;
               if (held_in_range) begin
                  valid_in[held_addr] = 1'b1;
               end
               rsp_load    = 1'b1;
               rsp_in      = '0;
               rsp_in.kind = oamls_pkg::KIND_WRITE;
               rsp_in.last = 1'b1;
               state_in    = oamls_pkg::ST_IDLE;
            end
         end

         oamls_pkg::ST_READ: begin
            if (out_free) begin
               rsp_load         = 1'b1;
               rsp_in           = '0;
               rsp_in.kind      = oamls_pkg::KIND_READ;
               rsp_in.read_data = held_in_range ? read_byte : oamls_pkg::READ_MISS;
               rsp_in.last      = 1'b1;
               state_in         = oamls_pkg::ST_IDLE;
            end
         end

         oamls_pkg::ST_SCAN: begin
            // Issue one entry read per cycle, test it the cycle after
            ram_rd_addr = scan_idx_ff[AddrW-1:0];
            if (hit) begin
               list_in  = list_ins;
               count_in = count_ff + CntW'(1);
            end
            if (scan_done) begin
               state_in = oamls_pkg::ST_EMIT;
               emit_in  = '0;
            end else begin
               pend_in     = issue;
               pend_idx_in = scan_idx_ff[AddrW-1:0];
               if (issue) begin
                  scan_idx_in = scan_idx_ff + IdxW'(1);
               end
            end
         end

         oamls_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_load = 1'b1;
               rsp_in   = '0;
               if (count_ff == '0) begin
                  rsp_in.kind = oamls_pkg::KIND_EMPTY;
                  rsp_in.last = 1'b1;
                  state_in    = oamls_pkg::ST_IDLE;
               end else begin
                  rsp_in.kind        = oamls_pkg::KIND_SPRITE;
                  rsp_in.sprite_y    = emit_pick.entry.y;
                  rsp_in.sprite_x    = emit_pick.entry.x;
                  rsp_in.sprite_tile = emit_pick.entry.tile;
                  rsp_in.sprite_attr = emit_pick.entry.attr;
                  rsp_in.sprite_slot = emit_pick.slot;
                  rsp_in.last        = emit_last;
                  emit_in            = emit_ff + CntW'(1);
                  if (emit_last) begin
                     state_in = oamls_pkg::ST_IDLE;
                  end
               end
            end
         end

         default: begin
            state_in = oamls_pkg::ST_IDLE;
         end
      endcase

      // Output register: load a new result, or drop the taken one
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end

      // Track whether the entry being read was ever written
      rd_ok_in = valid_ff[ram_rd_addr];
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= oamls_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff    <= oamls_pkg::HEIGHT_RESET;
         valid_ff     <= '0;
         scan_idx_ff  <= '0;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         emit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         height_ff    <= height_in;
         valid_ff     <= valid_in;
         scan_idx_ff  <= scan_idx_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rd_ok_ff    <= rd_ok_in;
      pend_idx_ff <= pend_idx_in;
      list_ff     <= list_in;
      rsp_ff      <= rsp_in;
   end

   // Checks
   `OAMLS_ASSERT(a_count_bound, clock, reset, count_ff <= MaxCnt, "line count above limit")
   `OAMLS_ASSERT_IMPL(a_load_free, clock, reset, rsp_load, out_free, "result overwritten while stalled")
   `OAMLS_ASSERT_IMPL(a_emit_range, clock, reset, (state_ff == oamls_pkg::ST_EMIT) && (count_ff != '0), emit_ff < count_ff, "drain index past line count")
   `OAMLS_ASSERT_NEXT(a_write_path, clock, reset, req_accept && (req_data.command == oamls_pkg::CMD_WRITE), state_ff == oamls_pkg::ST_WRITE, "write transaction lost")

endmodule

`default_nettype wire

// ----- sim/oam_line_sprite_select_unit_tb.sv -----
// Self-checking testbench of the line sprite select unit: table traffic, scans, height settings.
`timescale 1ns / 1ps

module oam_line_sprite_select_unit_tb;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 100;
   localparam int PHASE_ITEMS = 70;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_enable = 1'b0;
   oamls_pkg::height_type csr_write_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   oamls_pkg::req_type    req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   oamls_pkg::rsp_type    rsp_data;

   // Sprite table predictor state
   oamls_pkg::entry_type  sprite_mem [oamls_pkg::TABLE_ENTRIES_DEF];
   oamls_pkg::pick_type   line_picks [oamls_pkg::MAX_PER_LINE_DEF];
   oamls_pkg::height_type height_now;

   oamls_pkg::req_type    request_backlog [$];
   oamls_pkg::rsp_type    expected_rsps [$];
   logic                  req_taken = 1'b0;
   logic                  steady_run = 1'b0;
   int                    mismatch_count = 0;
   int                    counted_items = 0;

   oam_line_sprite_select_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic oamls_pkg::rsp_type plain_rsp(input logic [1:0] kind, input logic last);
      oamls_pkg::rsp_type r;
      r = '0;
      r.kind = kind;
      r.last = last;
      return r;
   endfunction

   // Append one result to the expected list
   task automatic expect_rsp(input oamls_pkg::rsp_type o);
      expected_rsps = {expected_rsps, o};
   endtask

   // Apply one accepted command to the table copy and queue its results
   task automatic model_oam_command(input oamls_pkg::req_type r);
      int                 ent;
      int                 bsel;
      int                 target;
      int                 n;
      int                 j;
      int                 ey;
      int                 ex;
      oamls_pkg::rsp_type o;
      ent = int'(r.byte_address) / 4;
      bsel = int'(r.byte_address) % 4;
      case (r.command)
         oamls_pkg::CMD_WRITE: begin
            if (ent < oamls_pkg::TABLE_ENTRIES_DEF) begin
               case (bsel)
                  0: sprite_mem[ent].y = r.write_data;
                  1: sprite_mem[ent].x = r.write_data;
                  2: sprite_mem[ent].tile = r.write_data;
                  default: sprite_mem[ent].attr = r.write_data;
               endcase
            end
            expect_rsp(plain_rsp(oamls_pkg::KIND_WRITE, 1'b1));
         end
         oamls_pkg::CMD_READ: begin
            o = plain_rsp(oamls_pkg::KIND_READ, 1'b1);
            o.read_data = oamls_pkg::READ_MISS;
            if (ent < oamls_pkg::TABLE_ENTRIES_DEF) begin
               case (bsel)
                  0: o.read_data = sprite_mem[ent].y;
                  1: o.read_data = sprite_mem[ent].x;
                  2: o.read_data = sprite_mem[ent].tile;
                  default: o.read_data = sprite_mem[ent].attr;
               endcase
            end
            expect_rsp(o);
         end
         oamls_pkg::CMD_SCAN: begin
            target = int'(r.line) + oamls_pkg::LINE_OFFSET;
            n = 0;
            // Walk in table order, insert hits by x, equal x stays behind
            for (int i = 0; i < oamls_pkg::TABLE_ENTRIES_DEF
                 && n < oamls_pkg::MAX_PER_LINE_DEF; i++) begin
               ey = int'(sprite_mem[i].y);
               ex = int'(sprite_mem[i].x);
               if (ex > 0 && target >= ey && target < ey + int'(height_now)) begin
                  j = n;
                  while (j > 0 && int'(line_picks[j - 1].entry.x) > ex) begin
                     line_picks[j] = line_picks[j - 1];
                     j--;
                  end
                  line_picks[j].slot = oamls_pkg::slot_type'(i);
                  line_picks[j].entry = sprite_mem[i];
                  n++;
               end
            end
            if (n == 0) begin
               expect_rsp(plain_rsp(oamls_pkg::KIND_EMPTY, 1'b1));
            end else begin
               for (int i = 0; i < n; i++) begin
                  o = plain_rsp(oamls_pkg::KIND_SPRITE, i == n - 1);
                  o.sprite_y = line_picks[i].entry.y;
                  o.sprite_x = line_picks[i].entry.x;
                  o.sprite_tile = line_picks[i].entry.tile;
                  o.sprite_attr = line_picks[i].entry.attr;
                  o.sprite_slot = line_picks[i].slot;
                  expect_rsp(o);
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // Monitor: track accepted transactions and check each result
   always @(posedge clock) begin : monitor
      oamls_pkg::rsp_type want;
      req_taken = !reset && req_valid && !req_stall;
      if (reset) begin
         for (int i = 0; i < oamls_pkg::TABLE_ENTRIES_DEF; i++) sprite_mem[i] = '0;
         for (int i = 0; i < oamls_pkg::MAX_PER_LINE_DEF; i++) line_picks[i] = '0;
         height_now = oamls_pkg::HEIGHT_RESET;
      end else begin
         if (csr_write_enable) height_now = csr_write_data;
         if (req_taken) model_oam_command(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("result with no transaction pending: kind %0d", rsp_data.kind);
               mismatch_count++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("kind", int'(want.kind), int'(rsp_data.kind));
               check_field("read_data", int'(want.read_data), int'(rsp_data.read_data));
               check_field("sprite_y", int'(want.sprite_y), int'(rsp_data.sprite_y));
               check_field("sprite_x", int'(want.sprite_x), int'(rsp_data.sprite_x));
               check_field("sprite_tile", int'(want.sprite_tile),
                           int'(rsp_data.sprite_tile));
               check_field("sprite_attr", int'(want.sprite_attr),
                           int'(rsp_data.sprite_attr));
               check_field("sprite_slot", int'(want.sprite_slot),
                           int'(rsp_data.sprite_slot));
               check_field("last", int'(want.last), int'(rsp_data.last));
            end
         end
      end
   end

   // Driver: advance the request channel from the backlog, stall results at random
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            if (request_backlog.size() > 0 && (steady_run || $urandom_range(99) >= 20)) begin
               req_data <= request_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= !steady_run && ($urandom_range(99) < 20);
      end
   end

   task automatic queue_request(input logic [1:0] cmd, input int addr, input int wdata,
                                input int line_no);
      oamls_pkg::req_type r;
      r.command = cmd;
      r.byte_address = addr[7:0];
      r.write_data = wdata[7:0];
      r.line = line_no[7:0];
      request_backlog = {request_backlog, r};
      if (cmd != CMD_UNUSED) counted_items++;
   endtask

   task automatic queue_write(input int addr, input int wdata);
      queue_request(oamls_pkg::CMD_WRITE, addr, wdata, $urandom_range(255));
   endtask

   task automatic queue_read(input int addr);
      queue_request(oamls_pkg::CMD_READ, addr, $urandom_range(255), $urandom_range(255));
   endtask

   task automatic queue_scan(input int line_no);
      queue_request(oamls_pkg::CMD_SCAN, $urandom_range(255), $urandom_range(255), line_no);
   endtask

   // Hold the sender until every result is in, then let the block settle
   task automatic wait_idle();
      while (request_backlog.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_height(input int h);
      wait_idle();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= oamls_pkg::height_type'(h);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Fill one phase with sprite setups around a focus line, scans, reads and noise
   task automatic run_phase(input int h);
      int goal;
      int focus;
      int ent;
      int y;
      int x;
      int ln;
      goal = counted_items + PHASE_ITEMS;
      focus = $urandom_range(153);
      while (counted_items < goal) begin
         if ($urandom_range(99) < 70) begin
            if ($urandom_range(3) == 0) focus = $urandom_range(255);
            repeat ($urandom_range(1, 6)) begin
               ent = $urandom_range(oamls_pkg::TABLE_ENTRIES_DEF - 1);
               y = focus + oamls_pkg::LINE_OFFSET - $urandom_range(h + 3);
               if (y < 0) y = 0;
               if (y > 255) y = 255;
               x = ($urandom_range(4) == 0) ? $urandom_range(255) : $urandom_range(9);
               queue_write(ent * 4, y);
               queue_write(ent * 4 + 1, x);
               if ($urandom_range(1) == 1) begin
                  queue_write(ent * 4 + 2, $urandom_range(255));
                  queue_write(ent * 4 + 3, $urandom_range(255));
               end
            end
            repeat ($urandom_range(1, 3)) begin
               ln = focus + $urandom_range(3) - 1;
               if (ln < 0) ln = 0;
               if (ln > 255) ln = 255;
               queue_scan(ln);
            end
            queue_read($urandom_range(oamls_pkg::TABLE_ENTRIES_DEF * 4 - 1));
         end else begin
            queue_request(2'($urandom_range(3)), $urandom_range(255), $urandom_range(255),
                          $urandom_range(255));
         end
      end
   endtask

   initial begin
      int heights [6];
      heights = '{16, 8, 0, 31, 1, 0};
      heights[5] = $urandom_range(2, 30);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset contents, out-of-range bytes, empty line, ties, sorting, edges
      queue_read(0);
      queue_read(159);
      queue_read(160);
      queue_read(255);
      queue_write(255, 8'hAA);
      queue_scan(0);
      queue_request(CMD_UNUSED, 0, 0, 0);
      queue_write(0, 16);
      queue_write(1, 8);
      queue_write(4, 16);
      queue_write(5, 8);
      queue_write(8, 16);
      queue_write(156, 255);
      queue_write(157, 255);
      queue_write(158, 255);
      queue_write(159, 255);
      queue_scan(0);
      queue_write(1, 9);
      queue_scan(0);
      queue_scan(153);
      queue_scan(239);
      queue_scan(255);
      queue_read(159);
      queue_read(1);
      wait_idle();

      // Random phases over several heights, one with no idling at all
      for (int p = 0; p < 6; p++) begin
         set_height(heights[p]);
         steady_run = (p == 1);
         run_phase(heights[p]);
      end
      wait_idle();
      steady_run = 1'b0;

      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog on a hung handshake
   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+design
design/oamls_pkg.sv
design/oamls_ram.sv
design/oam_line_sprite_select_unit.sv
sim/oam_line_sprite_select_unit_tb.sv
